FILE: rtl/core/eqj_pkg.sv
`timescale 1ns / 1ps
// Shared package for the Euler angle to quaternion block: payload and control types,
// fixed-point constants and the elaboration-time sine table function.
// Depends on nothing; every other file of the block but eqj_stream_if imports it.
package eqj_pkg;

  localparam int EQJ_SINE_TABLE_DEPTH = 1024;
  localparam logic [63:0] EQJ_PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0] EQJ_INV_TWO_PI_Q32 = 64'd683565276;
  localparam logic [63:0] EQJ_Q30_ONE = 64'd1 << 30;
  localparam logic [14:0] EQJ_JUMP_THRESHOLD_RESET = 15'd4096;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } eqj_angles_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic               roll_jump;
    logic               pitch_jump;
    logic               yaw_jump;
  } eqj_attitude_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } eqj_quat_t;

  typedef struct packed {
    logic start;
    logic done_ready;
  } eqj_eng_ctrl_t;

  typedef struct packed {
    logic idle;
    logic done_valid;
  } eqj_eng_stat_t;

  typedef enum logic [1:0] {
    MUL_PHASE_HI,
    MUL_PHASE_LO,
    MUL_PAIR,
    MUL_TRIPLE
  } eqj_mul_op_t;

  typedef struct packed {
    logic               en;
    eqj_mul_op_t        op;
    logic [2:0]         idx;
    logic signed [31:0] a;
    logic signed [23:0] b;
  } eqj_mul_req_t;

  typedef struct packed {
    logic               en;
    eqj_mul_op_t        op;
    logic [2:0]         idx;
    logic signed [55:0] prod;
  } eqj_mul_rsp_t;

  // Sine of a Q30 angle as unsigned Q15, by a truncated odd Taylor series in Horner form.
  function automatic logic [15:0] eqj_sine_q15(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x2 = (x * x) >> 30;
    t = EQJ_Q30_ONE;
    t = EQJ_Q30_ONE - (((x2 * t) >> 30) / 64'd272);
    t = EQJ_Q30_ONE - (((x2 * t) >> 30) / 64'd210);
    t = EQJ_Q30_ONE - (((x2 * t) >> 30) / 64'd156);
    t = EQJ_Q30_ONE - (((x2 * t) >> 30) / 64'd110);
    t = EQJ_Q30_ONE - (((x2 * t) >> 30) / 64'd72);
    t = EQJ_Q30_ONE - (((x2 * t) >> 30) / 64'd42);
    t = EQJ_Q30_ONE - (((x2 * t) >> 30) / 64'd20);
    t = EQJ_Q30_ONE - (((x2 * t) >> 30) / 64'd6);
    s = (x * t) >> 30;
    return 16'((s + (64'd1 << 14)) >> 15);
  endfunction

  // Rounds a Q45 value to Q14, half away from zero, saturated to one.
  function automatic logic signed [15:0] eqj_to_q14(input logic signed [47:0] v);
    logic [47:0] mag;
    logic [47:0] rnd;
    logic [15:0] m;
    mag = v[47] ? 48'(-v) : 48'(v);
    rnd = (mag + (48'd1 << 30)) >> 31;
    if (rnd > 48'd16384) begin
      m = 16'd16384;
    end else begin
      m = rnd[15:0];
    end
    return v[47] ? $signed(16'(-m)) : $signed(m);
  endfunction

  // True when the angle rose by more than the threshold since the previous sample.
  function automatic logic eqj_rose_by(input logic signed [15:0] angle,
                                       input logic signed [15:0] prev,
                                       input logic [14:0] thr);
    logic signed [16:0] diff;
    diff = 17'(angle) - 17'(prev);
    return diff > $signed({2'b00, thr});
  endfunction

endpackage

FILE: rtl/core/eqj_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one payload per transaction.
// The payload type is set at instantiation, normally from eqj_pkg.
interface eqj_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

FILE: rtl/core/euler_to_quaternion_jump_check.sv
`timescale 1ns / 1ps
// Euler angle to quaternion converter with per-axis jump flags; top level.
// An accepted transaction presents its result held in an output register. A new one is
// taken only once that result is in the register: the shared multiplier runs 18 products
// in sequence, plus six sine table reads and their drain cycles.
// Reset (synchronous) clears the sequencer and the previous angles and loads the
// threshold with 0.5 rad; the sine table is constant and needs no fill.
module euler_to_quaternion_jump_check import eqj_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = EQJ_SINE_TABLE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write_en,
  input  logic [14:0]  cfg_write_data,
  eqj_stream_if.sink   angles,
  eqj_stream_if.source attitude
);

  localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);

  logic [14:0]        jump_threshold;
  logic signed [15:0] prev_roll;
  logic signed [15:0] prev_pitch;
  logic signed [15:0] prev_yaw;
  logic [2:0]         jump_pending;
  logic               out_valid;
  eqj_attitude_t      out_payload;

  logic               accept;
  logic               load;
  eqj_eng_ctrl_t      eng_ctrl;
  eqj_eng_stat_t      eng_stat;
  eqj_angles_t        in_angles;
  eqj_quat_t          eng_quat;
  eqj_mul_req_t       mul_req;
  eqj_mul_rsp_t       mul_rsp;
  logic [ADDR_W-1:0]  rom_addr;
  logic [15:0]        rom_data;

  assign in_angles = angles.payload;
  assign angles.ready = eng_stat.idle && !rst;
  assign accept = angles.valid && angles.ready;

  assign eng_ctrl.start = accept;
  assign eng_ctrl.done_ready = !out_valid || attitude.ready;
  assign load = eng_stat.done_valid && eng_ctrl.done_ready;

  assign attitude.valid = out_valid;
  assign attitude.payload = out_payload;

  always_ff @(posedge clk) begin
    if (rst) begin
      jump_threshold <= EQJ_JUMP_THRESHOLD_RESET;
      prev_roll      <= '0;
      prev_pitch     <= '0;
      prev_yaw       <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        jump_threshold <= cfg_write_data;
      end
      if (accept) begin
        prev_roll  <= in_angles.roll_angle;
        prev_pitch <= in_angles.pitch_angle;
        prev_yaw   <= in_angles.yaw_angle;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (attitude.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      jump_pending <= {eqj_rose_by(in_angles.roll_angle, prev_roll, jump_threshold),
                       eqj_rose_by(in_angles.pitch_angle, prev_pitch, jump_threshold),
                       eqj_rose_by(in_angles.yaw_angle, prev_yaw, jump_threshold)};
    end
    if (load) begin
      out_payload.quat_w     <= eng_quat.quat_w;
      out_payload.quat_x     <= eng_quat.quat_x;
      out_payload.quat_y     <= eng_quat.quat_y;
      out_payload.quat_z     <= eng_quat.quat_z;
      out_payload.roll_jump  <= jump_pending[2];
      out_payload.pitch_jump <= jump_pending[1];
      out_payload.yaw_jump   <= jump_pending[0];
    end
  end

  eqj_engine #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (eng_ctrl),
    .stat    (eng_stat),
    .angles  (in_angles),
    .quat    (eng_quat),
    .mul_req (mul_req),
    .mul_rsp (mul_rsp),
    .rom_addr(rom_addr),
    .rom_data(rom_data)
  );

  eqj_mul_unit u_mul (
    .clk(clk),
    .rst(rst),
    .req(mul_req),
    .rsp(mul_rsp)
  );

  eqj_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_rom (
    .clk (clk),
    .addr(rom_addr),
    .data(rom_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !angles.ready)
    else $error("Input still ready in the cycle after a transaction was accepted.");

  a_result_after_load: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("Finished result was not presented on the output.");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !attitude.ready) |=> (out_valid && $stable(out_payload)))
    else $error("Waiting result changed before it was taken.");

endmodule

FILE: rtl/core/eqj_sine_rom.sv
`timescale 1ns / 1ps
// Quarter-wave sine table with registered read, built at elaboration.
// Depends on eqj_pkg for the table function and constants.
module eqj_sine_rom import eqj_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = EQJ_SINE_TABLE_DEPTH,
  localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] addr,
  output logic [15:0]       data
);

  logic [15:0] rom_table [SINE_TABLE_DEPTH + 1];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_entry
    localparam logic [63:0] X = (64'(k) * EQJ_PI_HALF_Q30 + 64'(SINE_TABLE_DEPTH / 2))
                                / 64'(SINE_TABLE_DEPTH);
    assign rom_table[k] = eqj_sine_q15(X);
  end

  always_ff @(posedge clk) begin
    data <= rom_table[addr];
  end

endmodule

FILE: rtl/core/eqj_mul_unit.sv
`timescale 1ns / 1ps
// Shared signed 32 by 24 bit multiplier with a registered product and tag.
// Depends on eqj_pkg for the request and response types.
module eqj_mul_unit import eqj_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  eqj_mul_req_t req,
  output eqj_mul_rsp_t rsp
);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.en <= 1'b0;
    end else begin
      rsp.en <= req.en;
    end
    rsp.op   <= req.op;
    rsp.idx  <= req.idx;
    rsp.prod <= 56'(req.a) * 56'(req.b);
  end

endmodule

FILE: rtl/core/eqj_engine.sv
`timescale 1ns / 1ps
// Sequencer and datapath registers: phase scaling, table lookups, pair and triple
// products, all through the shared multiplier and the sine table.
// Depends on eqj_pkg; works with eqj_mul_unit and eqj_sine_rom.
module eqj_engine import eqj_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = EQJ_SINE_TABLE_DEPTH,
  localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  eqj_eng_ctrl_t     ctrl,
  output eqj_eng_stat_t     stat,
  input  eqj_angles_t       angles,
  output eqj_quat_t         quat,
  output eqj_mul_req_t      mul_req,
  input  eqj_mul_rsp_t      mul_rsp,
  output logic [ADDR_W-1:0] rom_addr,
  input  logic [15:0]       rom_data
);

  localparam int PHASE_W = $clog2(4 * SINE_TABLE_DEPTH);
  localparam logic [63:0] PHASE_K = 64'(4 * SINE_TABLE_DEPTH) * EQJ_INV_TWO_PI_Q32;
  localparam logic [22:0] PHASE_K_LO = PHASE_K[22:0];
  localparam logic [22:0] PHASE_K_HI = PHASE_K[45:23];
  localparam logic [63:0] PHASE_ROUND = 64'd1 << 45;
  localparam logic [PHASE_W-1:0] QUARTER = PHASE_W'(SINE_TABLE_DEPTH);
  localparam logic [PHASE_W-1:0] HALF = PHASE_W'(2 * SINE_TABLE_DEPTH);
  localparam logic [PHASE_W-1:0] THREE_QUARTER = PHASE_W'(3 * SINE_TABLE_DEPTH);
  localparam int AXIS_ROLL = 0;
  localparam int AXIS_PITCH = 1;
  localparam int AXIS_YAW = 2;
  localparam logic [3:0] PHASE_LAST = 4'd6;
  localparam logic [3:0] LOOKUP_LAST = 4'd6;
  localparam logic [3:0] PAIR_LAST = 4'd4;
  localparam logic [3:0] TRIPLE_LAST = 4'd9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PHASE,
    ST_LOOKUP,
    ST_PAIR,
    ST_TRIPLE,
    ST_DONE
  } state_t;

  state_t state;
  logic [3:0] cnt;

  logic [2:0]          neg;
  logic [15:0]         mag [3];
  logic [37:0]         hi_prod;
  logic [PHASE_W-1:0]  phase [3];
  logic signed [16:0]  sin_val [3];
  logic signed [16:0]  cos_val [3];
  logic signed [31:0]  pair [4];
  logic signed [47:0]  acc;
  logic signed [47:0]  sum_reg;
  logic                round_en;
  logic [1:0]          round_idx;
  logic signed [15:0]  quat_reg [4];
  logic                lk_en;
  logic [1:0]          lk_angle;
  logic                lk_cos;
  logic                lk_neg;

  logic                lk_issue;
  logic [1:0]          lk_sel;
  logic [PHASE_W-1:0]  lk_phase;
  logic [PHASE_W-1:0]  lk_rem;
  logic [1:0]          lk_quad;
  logic [63:0]         phase_sum;
  logic signed [47:0]  triple_prod;
  logic signed [16:0]  rom_signed;

  // The sequencer: one clocked block for state and step count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (ctrl.start) begin
            state <= ST_PHASE;
          end
        end
        ST_PHASE: begin
          if (cnt == PHASE_LAST) begin
            state <= ST_LOOKUP;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        ST_LOOKUP: begin
          if (cnt == LOOKUP_LAST) begin
            state <= ST_PAIR;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        ST_PAIR: begin
          if (cnt == PAIR_LAST) begin
            state <= ST_TRIPLE;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        ST_TRIPLE: begin
          if (cnt == TRIPLE_LAST) begin
            state <= ST_DONE;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        ST_DONE: begin
          if (ctrl.done_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
          cnt   <= '0;
        end
      endcase
    end
  end

  assign stat.idle       = (state == ST_IDLE);
  assign stat.done_valid = (state == ST_DONE);

  // Table address for the sine or cosine of one half angle.
  assign lk_issue = (state == ST_LOOKUP) && (cnt < 4'd6);
  assign lk_sel   = cnt[2:1];

  always_comb begin
    lk_phase = phase[lk_sel] + (cnt[0] ? QUARTER : '0);
    if (lk_phase >= THREE_QUARTER) begin
      lk_quad = 2'd3;
      lk_rem  = lk_phase - THREE_QUARTER;
    end else if (lk_phase >= HALF) begin
      lk_quad = 2'd2;
      lk_rem  = lk_phase - HALF;
    end else if (lk_phase >= QUARTER) begin
      lk_quad = 2'd1;
      lk_rem  = lk_phase - QUARTER;
    end else begin
      lk_quad = 2'd0;
      lk_rem  = lk_phase;
    end
    rom_addr = lk_quad[0] ? ADDR_W'(QUARTER - lk_rem) : ADDR_W'(lk_rem);
  end

  // Multiplier requests for each step of the schedule.
  always_comb begin
    mul_req = '0;
    case (state)
      ST_PHASE: begin
        if (cnt < 4'd6) begin
          mul_req.en  = 1'b1;
          mul_req.op  = cnt[0] ? MUL_PHASE_LO : MUL_PHASE_HI;
          mul_req.idx = {1'b0, cnt[2:1]};
          mul_req.a   = 32'(mag[cnt[2:1]]);
          mul_req.b   = {1'b0, (cnt[0] ? PHASE_K_LO : PHASE_K_HI)};
        end
      end
      ST_PAIR: begin
        if (cnt < 4'd4) begin
          mul_req.en  = 1'b1;
          mul_req.op  = MUL_PAIR;
          mul_req.idx = {1'b0, cnt[1:0]};
          mul_req.a   = cnt[0] ? 32'(sin_val[AXIS_YAW]) : 32'(cos_val[AXIS_YAW]);
          mul_req.b   = (cnt[1:0] == 2'd0 || cnt[1:0] == 2'd3) ?
                        24'(cos_val[AXIS_ROLL]) : 24'(sin_val[AXIS_ROLL]);
        end
      end
      ST_TRIPLE: begin
        if (cnt < 4'd8) begin
          mul_req.en  = 1'b1;
          mul_req.op  = MUL_TRIPLE;
          mul_req.idx = cnt[2:0];
          case (cnt[2:0])
            3'd0: mul_req.a = pair[0];
            3'd1: mul_req.a = pair[1];
            3'd2: mul_req.a = pair[2];
            3'd3: mul_req.a = pair[3];
            3'd4: mul_req.a = pair[0];
            3'd5: mul_req.a = pair[1];
            3'd6: mul_req.a = pair[3];
            default: mul_req.a = pair[2];
          endcase
          case (cnt[2:0])
            3'd1, 3'd3, 3'd4, 3'd7: mul_req.b = 24'(sin_val[AXIS_PITCH]);
            default: mul_req.b = 24'(cos_val[AXIS_PITCH]);
          endcase
        end
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  assign phase_sum = (64'(hi_prod) << 23) + 64'(mul_rsp.prod[37:0]) + PHASE_ROUND;
  assign triple_prod = mul_rsp.prod[47:0];
  assign rom_signed = lk_neg ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});

  always_ff @(posedge clk) begin
    if (rst) begin
      lk_en    <= 1'b0;
      round_en <= 1'b0;
    end else begin
      lk_en    <= lk_issue;
      round_en <= mul_rsp.en && (mul_rsp.op == MUL_TRIPLE) && mul_rsp.idx[0];
    end
  end

  always_ff @(posedge clk) begin
    if (stat.idle && ctrl.start) begin
      neg <= {angles.yaw_angle[15], angles.pitch_angle[15], angles.roll_angle[15]};
      mag[AXIS_ROLL]  <= angles.roll_angle[15] ? 16'(-angles.roll_angle) : angles.roll_angle;
      mag[AXIS_PITCH] <= angles.pitch_angle[15] ?
                         16'(-angles.pitch_angle) : angles.pitch_angle;
      mag[AXIS_YAW]   <= angles.yaw_angle[15] ? 16'(-angles.yaw_angle) : angles.yaw_angle;
    end

    lk_angle <= lk_sel;
    lk_cos   <= cnt[0];
    lk_neg   <= lk_quad[1] ^ (!cnt[0] && neg[lk_sel]);
    if (lk_en) begin
      if (lk_cos) begin
        cos_val[lk_angle] <= rom_signed;
      end else begin
        sin_val[lk_angle] <= rom_signed;
      end
    end

    if (mul_rsp.en) begin
      case (mul_rsp.op)
        MUL_PHASE_HI: hi_prod <= mul_rsp.prod[37:0];
        MUL_PHASE_LO: phase[mul_rsp.idx[1:0]] <= phase_sum[46 +: PHASE_W];
        MUL_PAIR:     pair[mul_rsp.idx[1:0]] <= mul_rsp.prod[31:0];
        MUL_TRIPLE: begin
          if (!mul_rsp.idx[0]) begin
            acc <= triple_prod;
          end else if (mul_rsp.idx[1]) begin
            sum_reg <= acc - triple_prod;
          end else begin
            sum_reg <= acc + triple_prod;
          end
        end
        default: begin
          hi_prod <= hi_prod;
        end
      endcase
    end
    round_idx <= mul_rsp.idx[2:1];

    if (round_en) begin
      quat_reg[round_idx] <= eqj_to_q14(sum_reg);
    end
  end

  assign quat.quat_w = quat_reg[0];
  assign quat.quat_x = quat_reg[1];
  assign quat.quat_y = quat_reg[2];
  assign quat.quat_z = quat_reg[3];

  a_mul_rsp_in_schedule: assert property (@(posedge clk) disable iff (rst)
    mul_rsp.en |-> (state == ST_PHASE || state == ST_PAIR || state == ST_TRIPLE))
    else $error("Multiplier product arrived outside a multiply phase.");

  a_rom_read_in_lookup: assert property (@(posedge clk) disable iff (rst)
    lk_en |-> (state == ST_LOOKUP))
    else $error("Table data arrived outside the lookup phase.");

  a_start_only_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |-> (state == ST_IDLE))
    else $error("Start given while the sequencer was busy.");

  a_rounding_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> !round_en)
    else $error("Quaternion rounding still pending when the result was offered.");

endmodule

FILE: verif/euler_to_quaternion_jump_check_scoreboard.sv
`timescale 1ns / 1ps
// Attitude checker for euler_to_quaternion_jump_check: it watches the angle and attitude
// channels and the threshold port, predicts each quaternion and its jump flags, and compares.
// It depends on eqj_pkg and eqj_stream_if from the RTL.
module attitude_checker import eqj_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [14:0] cfg_write_data,
  eqj_stream_if       angles,
  eqj_stream_if       attitude,
  output int          mismatches,
  output int          outstanding,
  output int          checked,
  output int          jumps_seen,
  output int          full_scale_seen
);

  localparam int DEPTH = EQJ_SINE_TABLE_DEPTH;
  localparam longint unsigned TURN_STEPS = 4 * DEPTH;

  int unsigned        quarter_wave [0:DEPTH];
  logic [14:0]        threshold;
  logic signed [15:0] last_roll;
  logic signed [15:0] last_pitch;
  logic signed [15:0] last_yaw;
  eqj_attitude_t      attitude_due [$];

  initial begin
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned n;
    int k;
    mismatches = 0;
    outstanding = 0;
    checked = 0;
    jumps_seen = 0;
    full_scale_seen = 0;
    threshold = EQJ_JUMP_THRESHOLD_RESET;
    last_roll = '0;
    last_pitch = '0;
    last_yaw = '0;
    for (k = 0; k <= DEPTH; k++) begin
      x = (longint'(k) * EQJ_PI_HALF_Q30 + DEPTH / 2) / DEPTH;
      x2 = (x * x) >> 30;
      t = EQJ_Q30_ONE;
      for (n = 8; n >= 1; n--) begin
        t = EQJ_Q30_ONE - ((x2 * t) >> 30) / ((2 * n) * (2 * n + 1));
      end
      s = (x * t) >> 30;
      quarter_wave[k] = int'((s + (64'd1 << 14)) >> 15);
    end
  end

  function automatic int wave_at(longint unsigned phase);
    longint unsigned m;
    longint unsigned quadrant;
    longint unsigned offset;
    int v;
    m = phase % TURN_STEPS;
    quadrant = m / DEPTH;
    offset = m % DEPTH;
    v = quadrant[0] ? int'(quarter_wave[DEPTH - offset]) : int'(quarter_wave[offset]);
    return quadrant[1] ? -v : v;
  endfunction

  function automatic void half_angle(input logic signed [15:0] angle, output int sine,
                                     output int cosine);
    int a;
    longint unsigned mag;
    longint unsigned phase;
    a = angle;
    mag = a < 0 ? -a : a;
    phase = (mag * TURN_STEPS * EQJ_INV_TWO_PI_Q32 + (64'd1 << 45)) >> 46;
    sine = a < 0 ? -wave_at(phase) : wave_at(phase);
    cosine = wave_at(phase + DEPTH);
  endfunction

  function automatic logic signed [15:0] round_to_q14(input longint v);
    longint unsigned m;
    logic signed [15:0] res;
    m = v < 0 ? unsigned'(-v) : unsigned'(v);
    m = (m + (64'd1 << 30)) >> 31;
    if (m > 16384) begin
      m = 16384;
    end
    res = 16'(m);
    return v < 0 ? -res : res;
  endfunction

  function automatic logic rose_past_threshold(input logic signed [15:0] angle,
                                               input logic signed [15:0] prev);
    return (int'(angle) - int'(prev)) > int'(threshold);
  endfunction

  function automatic eqj_attitude_t predict_attitude(input eqj_angles_t a);
    int sr, cr, sp, cp, sy, cy;
    eqj_attitude_t r;
    half_angle(a.roll_angle, sr, cr);
    half_angle(a.pitch_angle, sp, cp);
    half_angle(a.yaw_angle, sy, cy);
    r.quat_w = round_to_q14(longint'(cy) * cr * cp + longint'(sy) * sr * sp);
    r.quat_x = round_to_q14(longint'(cy) * sr * cp - longint'(sy) * cr * sp);
    r.quat_y = round_to_q14(longint'(cy) * cr * sp + longint'(sy) * sr * cp);
    r.quat_z = round_to_q14(longint'(sy) * cr * cp - longint'(cy) * sr * sp);
    r.roll_jump = rose_past_threshold(a.roll_angle, last_roll);
    r.pitch_jump = rose_past_threshold(a.pitch_angle, last_pitch);
    r.yaw_jump = rose_past_threshold(a.yaw_angle, last_yaw);
    return r;
  endfunction

  function automatic int at_full_scale(input logic signed [15:0] v);
    return (v == 16'sd16384 || v == -16'sd16384) ? 1 : 0;
  endfunction

  always @(posedge clk) begin
    eqj_attitude_t due;
    eqj_attitude_t got;
    if (rst) begin
      threshold = EQJ_JUMP_THRESHOLD_RESET;
      last_roll = '0;
      last_pitch = '0;
      last_yaw = '0;
      attitude_due.delete();
    end else begin
      if (cfg_write_en) begin
        threshold = cfg_write_data;
      end
      if (angles.valid && angles.ready) begin
        attitude_due.push_back(predict_attitude(angles.payload));
        last_roll = angles.payload.roll_angle;
        last_pitch = angles.payload.pitch_angle;
        last_yaw = angles.payload.yaw_angle;
      end
      if (attitude.valid && attitude.ready) begin
        got = attitude.payload;
        if (attitude_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: attitude transaction with none expected: w %0d x %0d y %0d z %0d",
                     $realtime, got.quat_w, got.quat_x, got.quat_y, got.quat_z);
          end
        end else begin
          due = attitude_due.pop_front();
          checked++;
          jumps_seen += got.roll_jump + got.pitch_jump + got.yaw_jump;
          full_scale_seen += at_full_scale(got.quat_w) + at_full_scale(got.quat_x)
                             + at_full_scale(got.quat_y) + at_full_scale(got.quat_z);
          if (got.quat_w !== due.quat_w || got.quat_x !== due.quat_x ||
              got.quat_y !== due.quat_y || got.quat_z !== due.quat_z ||
              got.roll_jump !== due.roll_jump || got.pitch_jump !== due.pitch_jump ||
              got.yaw_jump !== due.yaw_jump) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: attitude mismatch, expected w %0d x %0d y %0d z %0d jumps %b%b%b",
                       $realtime, due.quat_w, due.quat_x, due.quat_y, due.quat_z,
                       due.roll_jump, due.pitch_jump, due.yaw_jump);
              $display("%0t:                      got w %0d x %0d y %0d z %0d jumps %b%b%b",
                       $realtime, got.quat_w, got.quat_x, got.quat_y, got.quat_z,
                       got.roll_jump, got.pitch_jump, got.yaw_jump);
            end
          end
        end
      end
    end
    outstanding = attitude_due.size();
  end

endmodule

FILE: verif/euler_to_quaternion_jump_check_test.sv
`timescale 1ns / 1ps
// Top of the euler_to_quaternion_jump_check testbench: clock, reset, angle stimulus with
// random gaps and stalls, threshold settings and the verdict. It depends on eqj_pkg,
// eqj_stream_if, the block itself and attitude_checker.
module euler_to_quaternion_jump_check_test import eqj_pkg::*;;

  localparam int IDLE_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [14:0] cfg_write_data = '0;

  eqj_stream_if #(.payload_t(eqj_angles_t)) angles_ch ();
  eqj_stream_if #(.payload_t(eqj_attitude_t)) attitude_ch ();

  int mismatches;
  int outstanding;
  int checked;
  int jumps_seen;
  int full_scale_seen;

  int samples_sent = 0;
  int settings_used = 1;
  int cur_threshold = EQJ_JUMP_THRESHOLD_RESET;
  int idle_cycles = 0;
  bit send_steady = 1'b0;
  bit take_steady = 1'b0;
  eqj_angles_t last_sent = '0;

  always #4 clk = ~clk;

  euler_to_quaternion_jump_check uut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .angles(angles_ch),
    .attitude(attitude_ch)
  );

  attitude_checker checker_i (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .angles(angles_ch),
    .attitude(attitude_ch),
    .mismatches(mismatches),
    .outstanding(outstanding),
    .checked(checked),
    .jumps_seen(jumps_seen),
    .full_scale_seen(full_scale_seen)
  );

  always @(posedge clk) begin
    if (rst || (angles_ch.valid && angles_ch.ready) ||
        (attitude_ch.valid && attitude_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timed out after %0d cycles without a transaction.", IDLE_LIMIT);
      $display("** euler_to_quaternion_jump_check: FAILED **");
      $finish;
    end
  end

  // The receiver holds ready low for a random stall, sometimes none, before taking each result.
  initial begin
    int stall;
    attitude_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) begin
        take_steady = !take_steady;
      end
      stall = take_steady ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        attitude_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      attitude_ch.ready = 1'b1;
      do @(posedge clk); while (!attitude_ch.valid);
      @(negedge clk);
    end
  end

  task automatic send_angles(input logic signed [15:0] roll, input logic signed [15:0] pitch,
                             input logic signed [15:0] yaw);
    int gap;
    if ($urandom_range(0, 29) == 0) begin
      send_steady = !send_steady;
    end
    gap = send_steady ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      angles_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    angles_ch.payload = '{roll_angle: roll, pitch_angle: pitch, yaw_angle: yaw};
    angles_ch.valid = 1'b1;
    do @(posedge clk); while (!angles_ch.ready);
    last_sent = '{roll_angle: roll, pitch_angle: pitch, yaw_angle: yaw};
    samples_sent++;
  endtask

  // Holds the sender back until every expected result has been taken.
  task automatic drain_results(input int extra_cycles);
    @(negedge clk);
    angles_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (extra_cycles) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [14:0] value);
    @(negedge clk);
    cfg_write_en = 1'b1;
    cfg_write_data = value;
    @(negedge clk);
    cfg_write_en = 1'b0;
    cur_threshold = value;
    settings_used++;
  endtask

  function automatic logic signed [15:0] next_angle(input logic signed [15:0] prev);
    int p;
    p = prev;
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1, 2: return 16'(p + cur_threshold + int'($urandom_range(0, 4)) - 2);
      3: return 16'(p - int'($urandom_range(0, 2000)));
      default: return 16'(int'($urandom_range(0, 51472)) - 25736);
    endcase
  endfunction

  task automatic random_samples(input int count);
    repeat (count) begin
      send_angles(next_angle(last_sent.roll_angle), next_angle(last_sent.pitch_angle),
                  next_angle(last_sent.yaw_angle));
    end
  endtask

  initial begin
    angles_ch.valid = 1'b0;
    angles_ch.payload = '0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // Reset threshold of 0.5 rad: first sample against zero, the boundary either side,
    // the ends of the range and wrapped out-of-range angles.
    send_angles(16'sd0, 16'sd0, 16'sd0);
    send_angles(16'sd4096, 16'sd4096, 16'sd4096);
    send_angles(16'sd8193, 16'sd8193, 16'sd8193);
    send_angles(16'sd25736, -16'sd25736, 16'sd12868);
    send_angles(-16'sd25736, 16'sd25736, -16'sd12868);
    send_angles(16'sd32767, -16'sd32768, 16'sd0);
    send_angles(-16'sd32768, 16'sd32767, -16'sd1);
    send_angles(16'sd12868, 16'sd12868, 16'sd12868);
    send_angles(16'sd6434, -16'sd6434, 16'sd19302);
    send_angles(16'sd1, -16'sd1, 16'sd25736);
    random_samples(320);

    drain_results(4);
    write_threshold(15'd0);
    send_angles(16'sd1, -16'sd1, 16'sd25736);
    send_angles(16'sd2, -16'sd1, 16'sd25735);
    random_samples(320);

    drain_results(4);
    write_threshold(15'd32767);
    send_angles(-16'sd32768, -16'sd32768, -16'sd32768);
    send_angles(-16'sd1, 16'sd0, 16'sd32767);
    send_angles(16'sd32766, -16'sd32768, 16'sd0);
    random_samples(320);

    drain_results(4);
    write_threshold(15'($urandom_range(1, 32766)));
    random_samples(320);

    drain_results(40);
    $display("Checked %0d of %0d samples over %0d threshold settings, both extremes included.",
             checked, samples_sent, settings_used);
    $display("Jump flags raised %0d times; %0d quaternion components at full scale.",
             jumps_seen, full_scale_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("** euler_to_quaternion_jump_check: PASSED **");
    end else begin
      $display("** euler_to_quaternion_jump_check: FAILED **");
    end
    $finish;
  end

endmodule
